### hw/rtl/fbrop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbrop_pkg;

    // Default size of the frame store in bytes.
    localparam int FB_BYTES_DEF = 65536;

    // Field widths.
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 32;
    localparam int ROP_W      = 8;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = 36;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd2;

    // Pixel formats and their byte counts.
    localparam logic       FMT_BGR    = 1'b0;
    localparam logic       FMT_BGRA   = 1'b1;
    localparam logic [2:0] BYTES_BGR  = 3'd3;
    localparam logic [2:0] BYTES_BGRA = 3'd4;

    // Operations and status codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_FAIL  = 1'b1;

    // Raster operation codes.
    localparam logic [ROP_W-1:0] ROP_COPY   = 8'd0;
    localparam logic [ROP_W-1:0] ROP_OR     = 8'd1;
    localparam logic [ROP_W-1:0] ROP_AND    = 8'd2;
    localparam logic [ROP_W-1:0] ROP_XOR    = 8'd3;
    localparam logic [ROP_W-1:0] ROP_CLR_R  = 8'd10;
    localparam logic [ROP_W-1:0] ROP_CLR_G  = 8'd11;
    localparam logic [ROP_W-1:0] ROP_CLR_B  = 8'd12;
    localparam logic [ROP_W-1:0] ROP_MASK   = 8'd20;
    localparam logic [ROP_W-1:0] ROP_ZERO_R = 8'd21;

    localparam logic [7:0] LSB_CLEAR = 8'hFE;
    localparam logic [7:0] MSB_MASK  = 8'h80;

    // Combines stored pixel px (bytes B, G, R, A from the low end) with the
    // source color. Bit 32 of the result is set for every known op code.
    function automatic logic [32:0] rop_apply(input logic [ROP_W-1:0]   code,
                                              input logic [COLOR_W-1:0] color,
                                              input logic [31:0]        px);
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] a;
        logic       chg;
        b   = px[7:0];
        g   = px[15:8];
        r   = px[23:16];
        a   = px[31:24];
        chg = 1'b1;
        case (code)
            ROP_COPY: begin
                b = color[7:0];
                g = color[15:8];
                r = color[23:16];
                a = color[31:24] + 8'd1;
            end
            ROP_OR: begin
                b = b | color[7:0];
                g = g | color[15:8];
                r = r | color[23:16];
            end
            ROP_AND: begin
                b = b & color[7:0];
                g = g & color[15:8];
                r = r & color[23:16];
            end
            ROP_XOR: begin
                b = b ^ color[7:0];
                g = g ^ color[15:8];
                r = r ^ color[23:16];
            end
            ROP_CLR_R:  r = r & LSB_CLEAR;
            ROP_CLR_G:  g = g & LSB_CLEAR;
            ROP_CLR_B:  b = b & LSB_CLEAR;
            ROP_MASK: begin
                b = b & MSB_MASK;
                g = g & MSB_MASK;
                r = r & MSB_MASK;
            end
            ROP_ZERO_R: r = 8'd0;
            default:    chg = 1'b0;
        endcase
        return {chg, a, r, g, b};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/framebuffer_raster_op_pixel_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Raster-op pixel port on a byte-addressed frame store of FB_BYTES bytes.
// Each input beat is a pixel read or a pixel write with a raster operation,
// and each gives exactly one output beat carrying a status (0 done, 1 clipped
// or past the end of the store) and, on a good read, the pixel as packed ARGB.
// Pixels are stored row by row as B, G, R (24 bpp) or B, G, R, A (32 bpp) at
// offset (screen_width * y + x) * bytes_per_pixel; the end of the pixel must
// lie inside the store. After reset the block zeroes the store one byte per
// cycle, all FB_BYTES (65536 by default) bytes of it; no input beat is
// taken during that sweep, though configuration writes are. A beat is then
// handled by a small sequencer around one 16x16 multiplier and one shared
// 36-bit adder, with the store reached through its single byte-wide port:
// it takes the beat, clips it and does the address arithmetic, reads the
// pixel, applies the raster op, writes the pixel back and presents the
// result. A clipped access goes straight to the result; a read, or a write
// with an unknown raster op code, skips the write-back. The port takes no
// new beat until the current one is in the output register; that register
// then waits for the downstream side while the next beat is already
// accepted. Configuration must only be written while no beat is in flight.
module framebuffer_raster_op_pixel_core #(
    parameter int FB_BYTES = fbrop_pkg::FB_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input beat. tdata fields from bit 0: op[0], x[16:1], y[32:17],
    // color[64:33], rop[72:65], zero padding [79:73].
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [fbrop_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // Result beat. tdata fields from bit 0: status[0], read_color[32:1],
    // zero padding [39:33].
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [fbrop_pkg::M_TDATA_W-1:0]       o_m_tdata,
    // Configuration write: 0 screen_width, 1 screen_height, 2 pixel_format.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [fbrop_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fbrop_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fbrop_pkg::*;

    localparam int                AW      = $clog2(FB_BYTES);
    localparam logic [ACC_W-1:0]  LIMIT   = ACC_W'(FB_BYTES);
    localparam logic [AW-1:0]     LAST_AD = AW'(FB_BYTES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ADD,
        S_SCALE,
        S_CHECK,
        S_READ,
        S_OP,
        S_WRITE,
        S_DONE
    } t_state;

    // Control and configuration registers.
    t_state                  r_state,    n_state;
    logic [COORD_W-1:0]      r_width,    n_width;
    logic [COORD_W-1:0]      r_height,   n_height;
    logic                    r_fmt,      n_fmt;
    logic                    r_m_tvalid, n_m_tvalid;
    logic [AW-1:0]           r_addr,     n_addr;
    logic [2:0]              r_cnt,      n_cnt;

    // Payload registers.
    logic                    r_op,       n_op;
    logic [COORD_W-1:0]      r_x,        n_x;
    logic [COORD_W-1:0]      r_y,        n_y;
    logic [COLOR_W-1:0]      r_color,    n_color;
    logic [ROP_W-1:0]        r_rop,      n_rop;
    logic [ACC_W-1:0]        r_acc,      n_acc;
    logic [AW-1:0]           r_base,     n_base;
    logic [31:0]             r_px,       n_px;
    logic                    r_status,   n_status;
    logic [COLOR_W-1:0]      r_res,      n_res;
    logic [M_TDATA_W-1:0]    r_m_tdata,  n_m_tdata;

    // Frame store and its port.
    logic [7:0]              r_mem [FB_BYTES];
    logic [7:0]              r_rd;
    logic                    mem_we;
    logic [AW-1:0]           mem_wa;
    logic [7:0]              mem_wd;

    // Shared arithmetic.
    logic [ACC_W-1:0]        add_a;
    logic [ACC_W-1:0]        add_b;
    logic [ACC_W-1:0]        add_res;
    logic [2*COORD_W-1:0]    prod;
    logic [2:0]              nbytes;
    logic [32:0]             rop_out;
    logic [1:0]              cap_idx;
    logic                    s_fire;

    assign nbytes      = (r_fmt == FMT_BGRA) ? BYTES_BGRA : BYTES_BGR;
    assign prod        = {16'd0, r_width} * {16'd0, r_y};
    assign add_res     = add_a + add_b;
    assign rop_out     = rop_apply(r_rop, r_color, r_px);
    assign cap_idx     = 2'(r_cnt - 3'd1);

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign o_cfg_ready = 1'b1;

    // Operand selection for the shared adder.
    always_comb begin
        add_a = r_acc;
        add_b = '0;
        case (r_state)
            S_ADD: begin
                add_b = ACC_W'(r_x);
            end
            S_SCALE: begin
                if (r_fmt == FMT_BGRA) begin
                    add_a = {r_acc[ACC_W-3:0], 2'b00};
                end else begin
                    add_a = {r_acc[ACC_W-2:0], 1'b0};
                    add_b = r_acc;
                end
            end
            S_CHECK: begin
                add_b = ACC_W'(nbytes);
            end
            default: begin
                add_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_width    = r_width;
        n_height   = r_height;
        n_fmt      = r_fmt;
        n_m_tvalid = r_m_tvalid;
        n_addr     = r_addr;
        n_cnt      = r_cnt;
        n_op       = r_op;
        n_x        = r_x;
        n_y        = r_y;
        n_color    = r_color;
        n_rop      = r_rop;
        n_acc      = r_acc;
        n_base     = r_base;
        n_px       = r_px;
        n_status   = r_status;
        n_res      = r_res;
        n_m_tdata  = r_m_tdata;
        mem_we     = 1'b0;
        mem_wa     = r_addr;
        mem_wd     = 8'd0;

        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WIDTH:  n_width  = i_cfg_data;
                CFG_HEIGHT: n_height = i_cfg_data;
                CFG_FORMAT: n_fmt    = i_cfg_data[0];
                default:    n_width  = r_width;
            endcase
        end

        if (r_m_tvalid && i_m_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST_AD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    n_op    = i_s_tdata[0];
                    n_x     = i_s_tdata[16:1];
                    n_y     = i_s_tdata[32:17];
                    n_color = i_s_tdata[64:33];
                    n_rop   = i_s_tdata[72:65];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc    = ACC_W'(prod);
                n_status = ST_FAIL;
                n_res    = '0;
                if (r_x >= r_width || r_y >= r_height) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_acc   = add_res;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_acc   = add_res;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // The last byte of the pixel must lie inside the store.
                if (add_res > LIMIT) begin
                    n_state = S_DONE;
                end else begin
                    n_addr  = r_acc[AW-1:0];
                    n_base  = r_acc[AW-1:0];
                    n_px    = '0;
                    n_cnt   = 3'd0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // Read data arrives in the cycle after its address.
                if (r_cnt < nbytes) begin
                    n_addr = r_addr + AW'(1);
                end
                if (r_cnt != 3'd0) begin
                    n_px[{cap_idx, 3'b000} +: 8] = r_rd;
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == nbytes) begin
                    n_state = S_OP;
                end
            end
            S_OP: begin
                n_status = ST_OK;
                if (r_op == OP_READ) begin
                    n_res   = r_px;
                    n_state = S_DONE;
                end else if (rop_out[32]) begin
                    n_px    = rop_out[31:0];
                    n_addr  = r_base;
                    n_cnt   = 3'd0;
                    n_state = S_WRITE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WRITE: begin
                mem_we = 1'b1;
                mem_wd = r_px[{r_cnt[1:0], 3'b000} +: 8];
                n_addr = r_addr + AW'(1);
                n_cnt  = r_cnt + 3'd1;
                if (r_cnt == nbytes - 3'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {7'd0, r_res, r_status};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_width    <= '0;
            r_height   <= '0;
            r_fmt      <= FMT_BGRA;
            r_m_tvalid <= 1'b0;
            r_addr     <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_width    <= n_width;
            r_height   <= n_height;
            r_fmt      <= n_fmt;
            r_m_tvalid <= n_m_tvalid;
            r_addr     <= n_addr;
            r_cnt      <= n_cnt;
        end
        r_op      <= n_op;
        r_x       <= n_x;
        r_y       <= n_y;
        r_color   <= n_color;
        r_rop     <= n_rop;
        r_acc     <= n_acc;
        r_base    <= n_base;
        r_px      <= n_px;
        r_status  <= n_status;
        r_res     <= n_res;
        r_m_tdata <= n_m_tdata;
    end

    // Single-port byte store with a registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[r_addr];
    end

`ifndef ASSERT_OFF
    // The store is written only by the clearing sweep and the write-back.
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_WRITE))
        else $error("store written outside clear or write-back");

    // Write-back never runs past the bytes of one pixel.
    a_wr_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_cnt < nbytes))
        else $error("write-back past end of pixel");

    // A failed access carries no color.
    a_fail_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == ST_OK || o_m_tdata[32:1] == '0))
        else $error("failed access returned a color");

    // An accepted beat goes straight to the address arithmetic.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (r_state == S_MUL))
        else $error("accepted beat not started");
`endif

endmodule

`default_nettype wire
